@@ src/dfd_pkg.sv @@
// Package for the delimited frame deframer: phase codes, constants and the
// result record shared by the core and the top level. No dependencies.
package dfd_pkg;

    localparam int unsigned BUF_DEPTH   = 256;
    localparam int unsigned CAP_W       = 9;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned CNT_W       = 16;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 9;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 80;
    localparam int unsigned M_TUSER_W   = 1;

    localparam logic [7:0]            START_MARK = 8'h7E;
    localparam logic [7:0]            SUM_GOOD   = 8'hFF;
    localparam logic [CNT_W-1:0]      CNT_MAX    = '1;
    localparam logic [CAP_W:0]        BUF_CAP    = (CAP_W + 1)'(BUF_DEPTH);

    localparam logic [CFG_IDX_W-1:0]  REG_ONLY_GOOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_CAPACITY  = 1'd1;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_API    = 3'd3,
        PH_BODY   = 3'd4
    } phase_t;

    typedef struct packed {
        logic             only_good;
        logic [CAP_W-1:0] capacity;
    } cfg_t;

    typedef struct packed {
        logic             data_valid;
        logic [7:0]       data_byte;
        logic [7:0]       data_index;
        logic             frame_done;
        logic             frame_accepted;
        logic             checksum_good;
        logic [7:0]       frame_api;
        logic [LEN_W-1:0] declared_length;
        logic             frame_overflowed;
        logic [CNT_W-1:0] overflow_frames;
        logic [CNT_W-1:0] bad_checksum_frames;
    } result_t;

endpackage

@@ src/delimited_frame_deframer_top.sv @@
// Top level of the delimited frame deframer: configuration registers,
// stream ports and a two-entry output buffer. Depends on dfd_pkg, dfd_core.
//
// Takes one received byte per transfer and returns one result per byte,
// sustaining one transfer per clock cycle. A result is registered at the edge
// that takes its byte and, if no earlier result waits, is offered on the m_
// side from the next cycle; the core's frame state is updated at that same
// edge, so the next byte may follow at once. A second output entry lets one
// more byte be taken while a result waits; s_tready falls only when both are
// occupied. Frames start at 0x7E, carry a big-endian 16-bit length, an API
// byte, the payload and a checksum byte; tlast marks the checksum byte.
module delimited_frame_deframer_top
    import dfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // [7:0] rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] data_byte, [15:8] data_index, [16] frame_accepted, [17] checksum_good,
    // [25:18] frame_api, [41:26] declared_length, [42] frame_overflowed,
    // [58:43] overflow_frames, [74:59] bad_checksum_frames, [79:75] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [M_TUSER_W-1:0]  m_tuser,  // [0] data_valid
    output logic                  m_tlast   // frame_done
);

    cfg_t    cfg_reg;
    result_t res_new;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    logic    s_take, m_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.only_good <= 1'b1;
            cfg_reg.capacity  <= BUF_CAP[CAP_W-1:0] | CAP_W'(BUF_DEPTH);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ONLY_GOOD: cfg_reg.only_good <= cfg_wdata[0];
                REG_CAPACITY:  cfg_reg.capacity  <= cfg_wdata[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !skid_valid_reg;
    assign s_take   = s_tvalid && s_tready;
    assign m_take   = main_valid_reg && m_tready;

    dfd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (s_take),
        .rx_byte (s_tdata[7:0]),
        .cfg     (cfg_reg),
        .result  (res_new)
    );

    always_comb begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        priority if (skid_valid_reg) begin
            if (m_take) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (s_take) begin
            if (!main_valid_reg || m_take) begin
                main_next       = res_new;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = res_new;
                skid_valid_next = 1'b1;
            end
        end else begin
            if (m_take) begin
                main_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = main_valid_reg;
    assign m_tlast  = main_reg.frame_done;
    assign m_tuser  = main_reg.data_valid;
    assign m_tdata  = {5'b00000,
                       main_reg.bad_checksum_frames,
                       main_reg.overflow_frames,
                       main_reg.frame_overflowed,
                       main_reg.declared_length,
                       main_reg.frame_api,
                       main_reg.checksum_good,
                       main_reg.frame_accepted,
                       main_reg.data_index,
                       main_reg.data_byte};

endmodule

@@ src/dfd_core.sv @@
// Deframer core: byte-wise frame state machine and running checksum.
// Produces one result per accepted byte. Depends on dfd_pkg.
module dfd_core
    import dfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_en,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output result_t    result
);

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [LEN_W-1:0] seen_reg, seen_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       api_reg, api_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] ovf_cnt_reg, ovf_cnt_next;
    logic [CNT_W-1:0] bad_cnt_reg, bad_cnt_next;

    logic [LEN_W-1:0] want;
    logic [CAP_W:0]   cap_eff;
    logic             good;

    always_comb begin
        want    = (length_reg != '0) ? length_reg - LEN_W'(1) : '0;
        cap_eff = ({1'b0, cfg.capacity} > BUF_CAP) ? BUF_CAP : {1'b0, cfg.capacity};
        sum_next     = sum_reg;
        good         = ((sum_reg + rx_byte) == SUM_GOOD);
        phase_next   = phase_reg;
        length_next  = length_reg;
        seen_next    = seen_reg;
        api_next     = api_reg;
        ovf_next     = ovf_reg;
        ovf_cnt_next = ovf_cnt_reg;
        bad_cnt_next = bad_cnt_reg;

        result = '0;

        unique case (phase_reg)
            PH_LEN_HI: begin
                length_next = {rx_byte, 8'h00};
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                length_next = {length_reg[LEN_W-1:8], rx_byte};
                phase_next  = PH_API;
            end
            PH_API: begin
                api_next   = rx_byte;
                sum_next   = rx_byte;
                seen_next  = '0;
                ovf_next   = 1'b0;
                phase_next = PH_BODY;
            end
            PH_BODY: begin
                sum_next = sum_reg + rx_byte;
                if (seen_reg < want) begin
                    if ({1'b0, seen_reg} < (LEN_W + 1)'(cap_eff)) begin
                        result.data_valid = 1'b1;
                        result.data_byte  = rx_byte;
                        result.data_index = seen_reg[7:0];
                    end else begin
                        if (!ovf_reg && ovf_cnt_reg != CNT_MAX) begin
                            ovf_cnt_next = ovf_cnt_reg + CNT_W'(1);
                        end
                        ovf_next = 1'b1;
                    end
                    seen_next = seen_reg + LEN_W'(1);
                end else begin
                    result.frame_done     = 1'b1;
                    result.checksum_good  = good;
                    result.frame_accepted = !cfg.only_good || good;
                    if (!good && bad_cnt_reg != CNT_MAX) begin
                        bad_cnt_next = bad_cnt_reg + CNT_W'(1);
                    end
                    phase_next = PH_HUNT;
                end
            end
            default: begin
                phase_next = (rx_byte == START_MARK) ? PH_LEN_HI : PH_HUNT;
            end
        endcase

        result.frame_api           = api_next;
        result.declared_length     = length_next;
        result.frame_overflowed    = ovf_next;
        result.overflow_frames     = ovf_cnt_next;
        result.bad_checksum_frames = bad_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            length_reg  <= '0;
            seen_reg    <= '0;
            sum_reg     <= '0;
            api_reg     <= '0;
            ovf_reg     <= 1'b0;
            ovf_cnt_reg <= '0;
            bad_cnt_reg <= '0;
        end else if (byte_en) begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            seen_reg    <= seen_next;
            sum_reg     <= sum_next;
            api_reg     <= api_next;
            ovf_reg     <= ovf_next;
            ovf_cnt_reg <= ovf_cnt_next;
            bad_cnt_reg <= bad_cnt_next;
        end
    end

endmodule

@@ tb/delimited_frame_deframer_top_tb.sv @@
// Testbench for delimited_frame_deframer_top: drives received bytes and register
// writes, predicts every result byte by byte and checks each transfer in order.
// Depends on dfd_pkg and the RTL of the deframer.
module delimited_frame_deframer_top_tb;
    import dfd_pkg::*;

    localparam int unsigned STALL_LIMIT = 1000;

    class deframer_ledger;
        phase_t           ph;
        logic [LEN_W-1:0] frame_len;
        logic [15:0]      body_count;
        logic [7:0]       sum;
        logic [7:0]       api;
        logic             overflowed;
        logic [CNT_W-1:0] ovf_tally;
        logic [CNT_W-1:0] bad_tally;
        logic             only_good;
        logic [CAP_W-1:0] capacity;
        result_t          byte_outcomes[$];
        int unsigned      mismatch_count;
        int unsigned      checked;

        function new();
            ph = PH_HUNT;
            frame_len = '0;
            body_count = '0;
            sum = '0;
            api = '0;
            overflowed = 1'b0;
            ovf_tally = '0;
            bad_tally = '0;
            only_good = 1'b1;
            capacity = CAP_W'(BUF_DEPTH);
            mismatch_count = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_ONLY_GOOD) begin
                only_good = val[0];
            end else if (idx == REG_CAPACITY) begin
                capacity = val[CAP_W-1:0];
            end
        endfunction

        // one accepted rx byte -> one expected result
        function void take_byte(logic [7:0] b);
            result_t     r;
            int unsigned want;
            int unsigned lim;
            r = '0;
            case (ph)
                PH_LEN_HI: begin
                    frame_len = {b, 8'h00};
                    ph = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    frame_len[7:0] = b;
                    ph = PH_API;
                end
                PH_API: begin
                    api = b;
                    sum = b;
                    body_count = '0;
                    overflowed = 1'b0;
                    ph = PH_BODY;
                end
                PH_BODY: begin
                    want = (frame_len != 0) ? frame_len - 1 : 0;
                    lim = (capacity > BUF_DEPTH) ? BUF_DEPTH : capacity;
                    sum = sum + b;
                    if (body_count < want) begin
                        if (body_count < lim) begin
                            r.data_valid = 1'b1;
                            r.data_byte = b;
                            r.data_index = body_count[7:0];
                        end else begin
                            if (!overflowed && ovf_tally != CNT_MAX)
                                ovf_tally = ovf_tally + CNT_W'(1);
                            overflowed = 1'b1;
                        end
                        body_count = body_count + 16'(1);
                    end else begin
                        r.frame_done = 1'b1;
                        r.checksum_good = (sum == SUM_GOOD);
                        if (!r.checksum_good && bad_tally != CNT_MAX)
                            bad_tally = bad_tally + CNT_W'(1);
                        r.frame_accepted = !only_good || r.checksum_good;
                        ph = PH_HUNT;
                    end
                end
                default: begin
                    ph = (b == START_MARK) ? PH_LEN_HI : PH_HUNT;
                end
            endcase
            r.frame_api = api;
            r.declared_length = frame_len;
            r.frame_overflowed = overflowed;
            r.overflow_frames = ovf_tally;
            r.bad_checksum_frames = bad_tally;
            byte_outcomes.push_back(r);
        endfunction

        task flag_mismatch(string msg);
            $display("[%0t] result %0d: %s", $time, checked, msg);
            mismatch_count++;
        endtask

        task cmp_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want) flag_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
        endtask

        task check_outcome(logic [M_TDATA_W-1:0] td, logic tu, logic tl);
            result_t exp_r;
            if (byte_outcomes.size() == 0) begin
                flag_mismatch("result transfer with nothing outstanding");
                return;
            end
            exp_r = byte_outcomes.pop_front();
            cmp_field("data_valid", 16'(tu), 16'(exp_r.data_valid));
            cmp_field("data_byte", 16'(td[7:0]), 16'(exp_r.data_byte));
            cmp_field("data_index", 16'(td[15:8]), 16'(exp_r.data_index));
            cmp_field("frame_done", 16'(tl), 16'(exp_r.frame_done));
            cmp_field("frame_accepted", 16'(td[16]), 16'(exp_r.frame_accepted));
            cmp_field("checksum_good", 16'(td[17]), 16'(exp_r.checksum_good));
            cmp_field("frame_api", 16'(td[25:18]), 16'(exp_r.frame_api));
            cmp_field("declared_length", td[41:26], exp_r.declared_length);
            cmp_field("frame_overflowed", 16'(td[42]), 16'(exp_r.frame_overflowed));
            cmp_field("overflow_frames", td[58:43], exp_r.overflow_frames);
            cmp_field("bad_checksum_frames", td[74:59], exp_r.bad_checksum_frames);
            checked++;
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;

    deframer_ledger ledger;
    int unsigned    tx_idle_pct = 0;
    int unsigned    rx_idle_pct = 0;
    int unsigned    bytes_sent = 0;
    int unsigned    quiet_cycles = 0;

    delimited_frame_deframer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) ledger.check_outcome(m_tdata, m_tuser[0], m_tlast);
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task send_rx_byte(logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        ledger.take_byte(b);
        bytes_sent++;
    endtask

    // byte count follows flen only when the frame is well formed
    task send_frame(logic [15:0] flen, int unsigned nbody, logic [7:0] api, bit good,
                    bit allow_mark);
        logic [7:0]  b;
        logic [7:0]  acc;
        int unsigned i;
        acc = api;
        send_rx_byte(START_MARK);
        send_rx_byte(flen[15:8]);
        send_rx_byte(flen[7:0]);
        send_rx_byte(api);
        for (i = 0; i < nbody; i++) begin
            b = (allow_mark && $urandom_range(15) == 0) ? START_MARK : 8'($urandom_range(255));
            if (!allow_mark && b == START_MARK) b = 8'h7F;
            acc = acc + b;
            send_rx_byte(b);
        end
        b = SUM_GOOD - acc;
        if (!good) b = b + 8'($urandom_range(1, 255));
        send_rx_byte(b);
    endtask

    // bring the deframer back to hunting with short lengths only
    task resync();
        while (ledger.ph != PH_HUNT) begin
            case (ledger.ph)
                PH_LEN_HI: send_rx_byte(8'h00);
                PH_LEN_LO: send_rx_byte(8'($urandom_range(12)));
                default:   send_rx_byte(8'($urandom_range(255)));
            endcase
        end
    endtask

    task settle();
        s_tvalid <= 1'b0;
        while (ledger.byte_outcomes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task apply_settings(bit only_good, logic [CAP_W-1:0] capacity);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_ONLY_GOOD;
        cfg_wdata <= CFG_DATA_W'(only_good);
        @(posedge aclk);
        cfg_index <= REG_CAPACITY;
        cfg_wdata <= CFG_DATA_W'(capacity);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ledger.set_reg(REG_ONLY_GOOD, CFG_DATA_W'(only_good));
        ledger.set_reg(REG_CAPACITY, CFG_DATA_W'(capacity));
    endtask

    task run_segment(int unsigned quota);
        int unsigned start;
        int unsigned pick;
        logic [15:0] flen;
        start = bytes_sent;
        while (bytes_sent - start < quota) begin
            resync();
            pick = $urandom_range(99);
            flen = 16'($urandom_range(12));
            if (pick < 70) begin
                send_frame(flen, (flen != 0) ? flen - 1 : 0, 8'($urandom_range(255)),
                           $urandom_range(99) < 70, 1'b1);
            end else if (pick < 85) begin
                send_frame(flen, $urandom_range(14), 8'($urandom_range(255)), 1'b1, 1'b0);
            end else begin
                // noise stops once a delimiter is seen, so lengths stay short
                repeat ($urandom_range(1, 3))
                    if (ledger.ph == PH_HUNT) send_rx_byte(8'($urandom_range(255)));
            end
        end
        resync();
    endtask

    initial begin
        ledger = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        tx_idle_pct = 35;
        rx_idle_pct = 45;

        // noise while hunting, empty frames, a delimiter inside the body, a bad sum
        send_rx_byte(8'h00);
        send_rx_byte(8'hFF);
        send_rx_byte(8'h7D);
        send_frame(16'h0000, 0, 8'hFF, 1'b1, 1'b0);
        send_frame(16'h0001, 0, 8'h5A, 1'b1, 1'b0);
        send_rx_byte(START_MARK);
        send_rx_byte(8'h00);
        send_rx_byte(8'h03);
        send_rx_byte(8'h00);
        send_rx_byte(START_MARK);
        send_rx_byte(8'hFF);
        send_rx_byte(8'h82);
        send_frame(16'h0002, 1, 8'h00, 1'b0, 1'b0);

        settle();
        apply_settings(1'b0, 9'd0);
        run_segment(20);
        settle();
        apply_settings(1'b1, 9'd1);
        run_segment(20);

        tx_idle_pct = 45;
        rx_idle_pct = 35;
        settle();
        apply_settings(1'b0, 9'd5);
        run_segment(20);
        settle();
        apply_settings(1'b1, 9'd511);
        send_frame(16'h0103, 258, 8'($urandom_range(255)), 1'b1, 1'b1);
        run_segment(10);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        settle();
        apply_settings(1'b1, 9'd256);
        run_segment(20);
        settle();
        apply_settings(1'b0, 9'd300);
        run_segment(20);

        settle();
        repeat (8) @(posedge aclk);
        if (ledger.mismatch_count == 0 && ledger.byte_outcomes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
